>>> sv/btrc_pkg.sv
// Shared constants and types for the breakpoint, trace and run-control unit.
package btrc_pkg;

	localparam int BTRC_BREAKPOINTS = 16;
	localparam int BTRC_TRACE_DEPTH = 1024;

	localparam int PC_W        = 32;
	localparam int TR_INDEX_W  = 10;
	localparam int CMD_W       = 3;
	localparam int STATUS_W    = 2;
	localparam int BP_HELD_W   = 5;
	localparam int TR_HELD_W   = 11;
	localparam int S_TDATA_W   = 80;
	localparam int S_TUSER_W   = 3;
	localparam int M_TDATA_W   = 56;

	localparam logic [1:0] OP_CYCLE  = 2'd0;
	localparam logic [1:0] OP_TOGGLE = 2'd1;
	localparam logic [1:0] OP_READ   = 2'd2;
	localparam logic [1:0] OP_CMD    = 2'd3;

	localparam logic [CMD_W-1:0] CMD_TOGGLE_PAUSE = 3'd0;
	localparam logic [CMD_W-1:0] CMD_STEP_INSN    = 3'd1;
	localparam logic [CMD_W-1:0] CMD_STEP_CYCLE   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_DEBUG_RUN    = 3'd3;
	localparam logic [CMD_W-1:0] CMD_HALT         = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BP_FULL = 2'd1;
	localparam logic [STATUS_W-1:0] ST_INDEX   = 2'd2;
	localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd3;

	typedef enum logic [3:0] {
		STEP_FREE  = 4'b0001,
		STEP_INSN  = 4'b0010,
		STEP_CYCLE = 4'b0100,
		STEP_DEBUG = 4'b1000
	} step_mode_t;

	typedef struct packed {
		logic                 paused;
		logic                 hit;
		logic [STATUS_W-1:0]  status;
		logic [BP_HELD_W-1:0] bp_held;
		logic [TR_HELD_W-1:0] tr_held;
		logic                 value_sel;
	} result_t;

endpackage

>>> sv/btrc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module btrc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> sv/breakpoint_trace_run_control.sv
// Debug unit: breakpoint table with parallel compare, PC trace RAM and run control.
// Result registered on input transfer; one item per cycle unless the output stalls.
// The trace RAM read is registered; its data bypasses the result register to the output.
// A stalled result blocks input, so the RAM read data holds until it is taken.
// Reset (arst_n low) empties the table and trace, clears pause and step mode.
// Table and trace contents are not cleared; only entries below the fill counts are read.
module breakpoint_trace_run_control
	import btrc_pkg::*;
#(
	parameter int BREAKPOINTS = BTRC_BREAKPOINTS,
	parameter int TRACE_DEPTH = BTRC_TRACE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// [31:0] pc, [63:32] target_address, [73:64] trace_index, [76:74] command
	input  logic [S_TDATA_W-1:0] s_axis_tdata,
	// [1:0] operation, [2] at_instruction_start
	input  logic [S_TUSER_W-1:0] s_axis_tuser,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// [0] paused, [1] breakpoint_hit, [3:2] status, [8:4] breakpoints_held,
	// [19:9] trace_held, [51:20] trace_value
	output logic [M_TDATA_W-1:0] m_axis_tdata
);

	localparam int BW  = $clog2(BREAKPOINTS + 1);
	localparam int AW  = $clog2(TRACE_DEPTH);
	localparam int FW  = $clog2(TRACE_DEPTH + 1);
	localparam int SW  = FW + 1;
	localparam int IXW = (FW > TR_INDEX_W) ? FW : TR_INDEX_W;

	// input fields
	logic [1:0]            op;
	logic                  start;
	logic [PC_W-1:0]       pc;
	logic [PC_W-1:0]       target;
	logic [TR_INDEX_W-1:0] tidx;
	logic [CMD_W-1:0]      cmd;

	assign op     = s_axis_tuser[1:0];
	assign start  = s_axis_tuser[2];
	assign pc     = s_axis_tdata[31:0];
	assign target = s_axis_tdata[63:32];
	assign tidx   = s_axis_tdata[73:64];
	assign cmd    = s_axis_tdata[76:74];

	// state
	logic [PC_W-1:0] bp_tab_q [BREAKPOINTS];
	logic [BW-1:0]   bp_fill_q, bp_fill_n;
	logic [AW-1:0]   tr_head_q, tr_head_n;
	logic [FW-1:0]   tr_fill_q, tr_fill_n;
	logic [PC_W-1:0] tr_last_q;
	logic            pause_q, pause_n;
	step_mode_t      step_q, step_n;
	logic            out_valid_q;
	result_t         res_q, res_n;

	logic acc;
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign acc           = s_axis_tvalid && s_axis_tready;

	// breakpoint compare, one comparator bank shared by cycles and toggles
	logic [PC_W-1:0]        cmp_addr;
	logic [BREAKPOINTS-1:0] bp_match;
	logic [BREAKPOINTS-1:0] bp_above;
	logic                   bp_any;

	assign cmp_addr = (op == OP_CYCLE) ? pc : target;
	assign bp_any   = |bp_match;

	always_comb begin
		for (int j = 0; j < BREAKPOINTS; j++) begin
			bp_match[j] = (BW'(j) < bp_fill_q) && (bp_tab_q[j] == cmp_addr);
		end
	end

	// entries at or above the matching one shift down on removal
	always_comb begin
		for (int j = 0; j < BREAKPOINTS; j++) begin
			bp_above[j] = 1'b0;
			for (int k = 0; k <= j; k++) begin
				bp_above[j] = bp_above[j] | bp_match[k];
			end
		end
	end

	logic toggle;
	assign toggle = acc && (op == OP_TOGGLE);

	for (genvar j = 0; j < BREAKPOINTS; j++) begin : g_bp
		if (j < BREAKPOINTS - 1) begin : g_shift
			always_ff @(posedge clk) begin
				if (toggle) begin
					if (bp_any) begin
						if (bp_above[j]) begin
							bp_tab_q[j] <= bp_tab_q[j+1];
						end
					end else if (BW'(j) == bp_fill_q) begin
						bp_tab_q[j] <= target;
					end
				end
			end
		end else begin : g_last
			always_ff @(posedge clk) begin
				if (toggle && !bp_any && (BW'(j) == bp_fill_q)) begin
					bp_tab_q[j] <= target;
				end
			end
		end
	end

	// trace addressing: ring position of head plus offset, folded once
	logic [SW-1:0]   wr_sum;
	logic [AW-1:0]   wr_addr;
	logic [IXW-1:0]  idx_ext;
	logic            idx_ok;
	logic [SW-1:0]   rd_sum;
	logic [AW-1:0]   rd_addr;
	logic [AW-1:0]   head_inc;
	logic            capture;
	logic            tr_we;
	logic            tr_re;
	logic [PC_W-1:0] tr_rdata;

	assign wr_sum  = SW'(tr_head_q) + SW'(tr_fill_q);
	assign wr_addr = (wr_sum >= SW'(TRACE_DEPTH)) ? AW'(wr_sum - SW'(TRACE_DEPTH))
	                                              : AW'(wr_sum);
	assign idx_ext = IXW'(tidx);
	assign idx_ok  = idx_ext < IXW'(tr_fill_q);
	assign rd_sum  = SW'(tr_head_q) + SW'(idx_ext);
	assign rd_addr = (rd_sum >= SW'(TRACE_DEPTH)) ? AW'(rd_sum - SW'(TRACE_DEPTH))
	                                              : AW'(rd_sum);
	assign head_inc = (tr_head_q == AW'(TRACE_DEPTH - 1)) ? '0 : tr_head_q + 1'b1;

	// newest entry is kept in tr_last_q, so the duplicate check needs no RAM read
	assign capture = acc && (op == OP_CYCLE) && start;
	assign tr_we   = capture && ((tr_fill_q == '0) || (tr_last_q != pc));
	assign tr_re   = acc && (op == OP_READ) && idx_ok;

	btrc_ram #(
		.WIDTH(PC_W),
		.DEPTH(TRACE_DEPTH)
	) u_trace_ram (
		.clk  (clk),
		.we   (tr_we),
		.waddr(wr_addr),
		.wdata(pc),
		.re   (tr_re),
		.raddr(rd_addr),
		.rdata(tr_rdata)
	);

	// next state and result
	logic active;
	assign active = pause_q || (step_q == STEP_DEBUG);

	always_comb begin
		bp_fill_n = bp_fill_q;
		tr_head_n = tr_head_q;
		tr_fill_n = tr_fill_q;
		pause_n   = pause_q;
		step_n    = step_q;
		res_n     = '0;
		res_n.status = ST_OK;

		if (tr_we) begin
			if (tr_fill_q == FW'(TRACE_DEPTH)) begin
				tr_head_n = head_inc;
			end else begin
				tr_fill_n = tr_fill_q + 1'b1;
			end
		end

		case (op)
			OP_CYCLE: begin
				if (start && bp_any) begin
					res_n.hit = 1'b1;
					pause_n   = 1'b1;
				end
				if (((step_q == STEP_INSN) && start) || (step_q == STEP_CYCLE)) begin
					pause_n = 1'b1;
					step_n  = STEP_FREE;
				end
			end
			OP_TOGGLE: begin
				if (bp_any) begin
					bp_fill_n = bp_fill_q - 1'b1;
				end else if (bp_fill_q == BW'(BREAKPOINTS)) begin
					res_n.status = ST_BP_FULL;
				end else begin
					bp_fill_n = bp_fill_q + 1'b1;
				end
			end
			OP_READ: begin
				if (idx_ok) begin
					res_n.value_sel = 1'b1;
				end else begin
					res_n.status = ST_INDEX;
				end
			end
			OP_CMD: begin
				case (cmd)
					CMD_TOGGLE_PAUSE: pause_n = !pause_q;
					CMD_HALT:         pause_n = 1'b1;
					CMD_STEP_INSN, CMD_STEP_CYCLE: begin
						if (!active) begin
							res_n.status = ST_IGNORED;
						end else begin
							step_n  = (cmd == CMD_STEP_INSN) ? STEP_INSN : STEP_CYCLE;
							pause_n = 1'b0;
						end
					end
					CMD_DEBUG_RUN: begin
						if (!active) begin
							res_n.status = ST_IGNORED;
						end else if (step_q == STEP_DEBUG) begin
							step_n  = STEP_FREE;
							pause_n = 1'b1;
						end else begin
							step_n  = STEP_DEBUG;
							pause_n = 1'b0;
						end
					end
					default: res_n.status = ST_IGNORED;
				endcase
			end
			default: res_n.status = ST_OK;
		endcase

		res_n.paused  = pause_n;
		res_n.bp_held = BP_HELD_W'(bp_fill_n);
		res_n.tr_held = TR_HELD_W'(tr_fill_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bp_fill_q   <= '0;
			tr_head_q   <= '0;
			tr_fill_q   <= '0;
			pause_q     <= 1'b0;
			step_q      <= STEP_FREE;
			out_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				bp_fill_q <= bp_fill_n;
				tr_head_q <= tr_head_n;
				tr_fill_q <= tr_fill_n;
				pause_q   <= pause_n;
				step_q    <= step_n;
			end
			if (acc) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			res_q <= res_n;
		end
		if (tr_we) begin
			tr_last_q <= pc;
		end
	end

	logic [PC_W-1:0] out_value;
	assign out_value = res_q.value_sel ? tr_rdata : '0;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'b0000, out_value, res_q.tr_held, res_q.bp_held,
	                        res_q.status, res_q.hit, res_q.paused};

	// checks
	a_hit_pauses: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && res_q.hit) |-> res_q.paused)
		else $error("breakpoint hit reported without pause");

	a_head_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		(tr_head_q != $past(tr_head_q)) |-> (tr_fill_q == FW'(TRACE_DEPTH)))
		else $error("trace head moved before the ring filled");

	a_bp_fill_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!acc |=> (bp_fill_q == $past(bp_fill_q)))
		else $error("breakpoint fill changed without a transfer");

	a_trace_grows: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (tr_fill_q >= $past(tr_fill_q)))
		else $error("trace fill decreased");

endmodule
